>>> rtl/core/jsu_pkg.sv
package jsu_pkg;

  localparam int QDEPTH      = 8;   // pending bytes waiting to be fed again
  localparam int STORE_DEPTH = 6;   // bytes held since an escape began
  localparam int BUF_DEPTH   = 8;   // result bytes of one input word

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [15:0] HI_MIN = 16'hD800;
  localparam logic [15:0] HI_MAX = 16'hDBFF;
  localparam logic [15:0] LO_MIN = 16'hDC00;
  localparam logic [15:0] LO_MAX = 16'hDFFF;

  localparam logic [20:0] UTF_MAX1 = 21'h00007F;
  localparam logic [20:0] UTF_MAX2 = 21'h0007FF;
  localparam logic [20:0] UTF_MAX3 = 21'h00FFFF;
  localparam logic [20:0] UTF_SUPP = 21'h010000;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_LEAD4 = 8'hF0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_ESC     = 4'd1,
    MODE_HEX     = 4'd2,
    MODE_HIGH    = 4'd3,
    MODE_HIGH_BS = 4'd4,
    MODE_LOW_HEX = 4'd5
  } scan_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } ctl_state_t;

  typedef struct packed {
    logic take;      // feed the accepted input byte
    logic step_q;    // feed the head of the pending queue
    logic finish;    // one end-of-string action
    logic load_out;  // move one result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic mode_normal;
    logic last_flag;
    logic has_out;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r.val = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      r.val = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.val = 4'(c - CH_UA + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp <= UTF_MAX1) begin
      r.b[0] = cp[7:0];
      r.n    = 3'd1;
    end else if (cp <= UTF_MAX2) begin
      r.b[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
      r.b[1] = UTF_CONT  | {2'b00, cp[5:0]};
      r.n    = 3'd2;
    end else if (cp <= UTF_MAX3) begin
      r.b[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
      r.b[1] = UTF_CONT  | {2'b00, cp[11:6]};
      r.b[2] = UTF_CONT  | {2'b00, cp[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = UTF_LEAD4 | {5'b00000, cp[20:18]};
      r.b[1] = UTF_CONT  | {2'b00, cp[17:12]};
      r.b[2] = UTF_CONT  | {2'b00, cp[11:6]};
      r.b[3] = UTF_CONT  | {2'b00, cp[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/json_string_unescape.sv
// channel | dir | signals                         | contents
// s       | in  | s_tvalid s_tready s_tdata s_tlast | escaped byte, tlast = end of string
// m       | out | m_tvalid m_tready m_tdata m_tlast | utf-8 byte, tlast = last of this word
//         |     | m_tuser                         | string end and has-byte flags
//
// a plain byte is accepted, then loaded into the output register
// each replayed byte and each end-of-string action takes its own step in the single scan unit
// result bytes leave one at a time through the one-word output register
// rst is synchronous; it clears the scan mode, counts and queue, not the byte stores
// input is taken once the last result of the previous word sits in the output register;
// m_tready low holds the output word and stops the drain
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] out_has_byte, [1] out_string_end
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  jsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jsu_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/core/jsu_ctrl.sv
module jsu_ctrl
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // replayed bytes first, then end-of-string actions, then drain
        priority if (!stat.q_empty) begin
          cmd.step_q = 1'b1;
        end else if (stat.last_flag && !stat.mode_normal) begin
          cmd.finish = 1'b1;
        end else if (!stat.has_out) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.drain_last) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

>>> rtl/core/jsu_datapath.sv
module jsu_datapath
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [1:0] m_tuser
);

  scan_mode_t  mode, mode_next;
  logic [15:0] first_unit, fu_next;
  logic [15:0] second_unit, su_next;
  logic [2:0]  digit_count, dc_next;
  logic [2:0]  replay_count, rc_next;
  logic [7:0]  store [STORE_DEPTH];
  logic [7:0]  q [QDEPTH];
  logic [7:0]  q_next [QDEPTH];
  logic [3:0]  qn, qn_next;
  logic [7:0]  rbuf [BUF_DEPTH];
  logic [3:0]  bn, bn_next;
  logic [2:0]  rd;
  logic        last_flag;

  logic [7:0]      fb;
  hex_t            hx;
  logic [15:0]     fu_shift, su_shift;
  logic [2:0]      dc_inc;
  utf8_t           enc_fu, enc_hex, enc_pair;
  logic [20:0]     cp_pair;
  logic            push, push_ok, rep, rep_extra;
  logic [3:0][7:0] em;
  logic [2:0]      em_n;
  logic [7:0]      store_eff [QDEPTH];
  logic [2:0]      rc_eff;
  logic [3:0]      head_n, rest_n, rest_off, j;
  logic [4:0]      qn_sum;
  logic [3:0]      bn_base, bn_sum;
  logic [3:0]      pos [4];
  logic            buf_we [4];
  logic            drain_last;
  logic            q_upd;

  assign fb       = cmd.take ? s_tdata : q[0];
  assign hx       = hex_decode(fb);
  assign fu_shift = {first_unit[11:0], hx.val};
  assign su_shift = {second_unit[11:0], hx.val};
  assign dc_inc   = digit_count + 3'd1;
  assign cp_pair  = UTF_SUPP + {1'b0, first_unit[9:0], su_shift[9:0]};
  assign enc_fu   = utf8_encode({5'd0, first_unit});
  assign enc_hex  = utf8_encode({5'd0, fu_shift});
  assign enc_pair = utf8_encode(cp_pair);

  // scan step: one byte fed, or one end-of-string action
  always_comb begin
    mode_next = mode;
    fu_next   = first_unit;
    su_next   = second_unit;
    dc_next   = digit_count;
    push      = 1'b0;
    rep       = 1'b0;
    rep_extra = 1'b0;
    em        = '0;
    em_n      = 3'd0;
    if (cmd.take || cmd.step_q) begin
      unique case (mode)
        MODE_ESC: begin
          mode_next = MODE_NORMAL;
          em_n      = 3'd1;
          unique case (fb)
            CH_B:    em[0] = CTL_BS;
            CH_F:    em[0] = CTL_FF;
            CH_N:    em[0] = CTL_LF;
            CH_R:    em[0] = CTL_CR;
            CH_T:    em[0] = CTL_TAB;
            CH_U: begin
              em_n      = 3'd0;
              mode_next = MODE_HEX;
              fu_next   = 16'd0;
              dc_next   = 3'd0;
            end
            default: em[0] = fb;
          endcase
        end
        MODE_HEX: begin
          if (!hx.ok) begin
            em[0]     = CH_U;
            em_n      = 3'd1;
            rep       = 1'b1;
            rep_extra = 1'b1;
          end else begin
            fu_next = fu_shift;
            push    = 1'b1;
            dc_next = dc_inc;
            if (dc_inc >= 3'd4) begin
              dc_next = 3'd0;
              if (fu_shift >= HI_MIN && fu_shift <= HI_MAX) begin
                mode_next = MODE_HIGH;
              end else begin
                mode_next = MODE_NORMAL;
                em        = enc_hex.b;
                em_n      = enc_hex.n;
              end
            end
          end
        end
        MODE_HIGH: begin
          if (fb == CH_BSL) begin
            push      = 1'b1;
            mode_next = MODE_HIGH_BS;
          end else begin
            em        = enc_fu.b;
            em_n      = enc_fu.n;
            rep       = 1'b1;
            rep_extra = 1'b1;
          end
        end
        MODE_HIGH_BS: begin
          if (fb == CH_U) begin
            push      = 1'b1;
            mode_next = MODE_LOW_HEX;
            su_next   = 16'd0;
            dc_next   = 3'd0;
          end else begin
            em        = enc_fu.b;
            em_n      = enc_fu.n;
            rep       = 1'b1;
            rep_extra = 1'b1;
          end
        end
        MODE_LOW_HEX: begin
          if (!hx.ok) begin
            em        = enc_fu.b;
            em_n      = enc_fu.n;
            rep       = 1'b1;
            rep_extra = 1'b1;
          end else begin
            su_next = su_shift;
            push    = 1'b1;
            dc_next = dc_inc;
            if (dc_inc >= 3'd4) begin
              if (su_shift >= LO_MIN && su_shift <= LO_MAX) begin
                dc_next   = 3'd0;
                mode_next = MODE_NORMAL;
                em        = enc_pair.b;
                em_n      = enc_pair.n;
              end else begin
                // unpaired high surrogate, replay all six held bytes
                em   = enc_fu.b;
                em_n = enc_fu.n;
                rep  = 1'b1;
              end
            end
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (fb == CH_BSL) begin
            mode_next = MODE_ESC;
          end else begin
            em[0] = fb;
            em_n  = 3'd1;
          end
        end
      endcase
    end else if (cmd.finish) begin
      unique case (mode)
        MODE_HEX: begin
          em[0] = CH_U;
          em_n  = 3'd1;
          rep   = 1'b1;
        end
        MODE_HIGH, MODE_HIGH_BS, MODE_LOW_HEX: begin
          em   = enc_fu.b;
          em_n = enc_fu.n;
          rep  = 1'b1;
        end
        default: begin
          mode_next = MODE_NORMAL;
          dc_next   = 3'd0;
        end
      endcase
    end
    if (rep) begin
      mode_next = MODE_NORMAL;
      dc_next   = 3'd0;
    end
  end

  // held bytes as they stand after this step's push
  assign push_ok = push && (replay_count < 3'(STORE_DEPTH));
  assign rc_eff  = push_ok ? replay_count + 3'd1 : replay_count;

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      store_eff[i] = 8'd0;
      if (i < STORE_DEPTH) begin
        store_eff[i] = store[i];
        if (push_ok && replay_count == 3'(i)) begin
          store_eff[i] = fb;
        end
      end
    end
  end

  always_comb begin
    rc_next = rc_eff;
    if (rep || dc_next == 3'd0 && mode_next != MODE_HIGH_BS && mode_next != MODE_LOW_HEX) begin
      rc_next = 3'd0;
    end
  end

  // replay puts the held bytes (and the failing byte) ahead of the rest of the queue
  assign rest_off = cmd.step_q ? 4'd1 : 4'd0;
  assign rest_n   = cmd.step_q ? qn - 4'd1 : 4'd0;
  assign head_n   = rep ? {1'b0, rc_eff} + {3'd0, rep_extra} : 4'd0;
  assign qn_sum   = {1'b0, head_n} + {1'b0, rest_n};
  assign qn_next  = (qn_sum > 5'(QDEPTH)) ? 4'(QDEPTH) : qn_sum[3:0];
  assign q_upd    = cmd.take || cmd.step_q || cmd.finish;

  always_comb begin
    j = 4'd0;
    for (int i = 0; i < QDEPTH; i++) begin
      j         = 4'(i) - head_n + rest_off;
      q_next[i] = q[j[2:0]];
      if (rep && 4'(i) < {1'b0, rc_eff}) begin
        q_next[i] = store_eff[i];
      end else if (rep && rep_extra && 4'(i) == {1'b0, rc_eff}) begin
        q_next[i] = fb;
      end
    end
  end

  // result bytes of this word, capped at the buffer depth
  assign bn_base = cmd.take ? 4'd0 : bn;
  assign bn_sum  = bn_base + {1'b0, em_n};
  assign bn_next = (bn_sum > 4'(BUF_DEPTH)) ? 4'(BUF_DEPTH) : bn_sum;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pos[k]    = bn_base + 4'(k);
      buf_we[k] = (3'(k) < em_n) && (pos[k] < 4'(BUF_DEPTH));
    end
  end

  assign drain_last = (bn == 4'd0) || ({1'b0, rd} + 4'd1 == bn);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      first_unit   <= 16'd0;
      second_unit  <= 16'd0;
      digit_count  <= 3'd0;
      replay_count <= 3'd0;
      qn           <= 4'd0;
      bn           <= 4'd0;
      rd           <= 3'd0;
      last_flag    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (q_upd) begin
        mode         <= mode_next;
        first_unit   <= fu_next;
        second_unit  <= su_next;
        digit_count  <= dc_next;
        replay_count <= rc_next;
        qn           <= qn_next;
        bn           <= bn_next;
      end
      if (cmd.take) begin
        last_flag <= s_tlast;
        rd        <= 3'd0;
      end else if (cmd.load_out) begin
        rd <= rd + 3'd1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[replay_count] <= fb;
    end
    if (q_upd) begin
      for (int i = 0; i < QDEPTH; i++) begin
        q[i] <= q_next[i];
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (q_upd && buf_we[k]) begin
        rbuf[pos[k][2:0]] <= em[k];
      end
    end
    if (cmd.load_out) begin
      m_tdata    <= (bn != 4'd0) ? rbuf[rd] : 8'd0;
      m_tuser[0] <= (bn != 4'd0);
      m_tuser[1] <= drain_last && last_flag;
      m_tlast    <= drain_last;
    end
  end

  assign stat.q_empty     = (qn == 4'd0);
  assign stat.mode_normal = (mode == MODE_NORMAL);
  assign stat.last_flag   = last_flag;
  assign stat.has_out     = (bn != 4'd0) || last_flag;
  assign stat.drain_last  = drain_last;
  assign stat.out_free    = !m_tvalid || m_tready;

`ifndef ASSERT_OFF
  a_take_queue_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (qn == 4'd0))
    else $error("input taken while replay bytes pending");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (qn == 4'd0))
    else $error("result drained while replay bytes pending");

  a_end_leaves_normal: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && last_flag && drain_last) |=> (mode == MODE_NORMAL && qn == 4'd0))
    else $error("string end left scanner busy");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tuser[1] && m_tlast && m_tdata == 8'd0))
    else $error("bare marker without string end");
`endif

endmodule
